// ----- design/sha_pkg.sv -----
package sha_pkg;

	localparam int unsigned WordW = 32;

	typedef logic [WordW-1:0] word_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_RUN,
		ST_ADD,
		ST_EMIT
	} state_t;

	// Input kinds
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic [7:0] PadByte = 8'h80;

	// Round constants
	function automatic word_t round_k(input logic [5:0] j);
		word_t k;
		unique case (j)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic word_t init_hash(input logic [2:0] i);
		word_t h;
		unique case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
			default: h = '0;
		endcase
		return h;
	endfunction

	typedef struct packed {
		logic       kind;
		logic [7:0] message_byte;
	} in_item_t;

	typedef struct packed {
		word_t digest_word;
		logic  last_word;
	} out_item_t;

endpackage

// ----- design/sha_stream_if.sv -----
interface sha_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/sha_round.sv -----
// One SHA-256 round, purely combinational.
module sha_round (
	input  sha_pkg::word_t vars_in [8],
	input  sha_pkg::word_t w,
	input  sha_pkg::word_t k,
	output sha_pkg::word_t vars_out [8]
);
	import sha_pkg::*;

	word_t s1, ch, s0, maj, t1, t2;

	always_comb begin
		s1  = {vars_in[4][5:0], vars_in[4][31:6]} ^ {vars_in[4][10:0], vars_in[4][31:11]}
			^ {vars_in[4][24:0], vars_in[4][31:25]};
		ch  = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
		s0  = {vars_in[0][1:0], vars_in[0][31:2]} ^ {vars_in[0][12:0], vars_in[0][31:13]}
			^ {vars_in[0][21:0], vars_in[0][31:22]};
		maj = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2])
			^ (vars_in[1] & vars_in[2]);
		t1  = vars_in[7] + s1 + ch + k + w;
		t2  = s0 + maj;
		vars_out[7] = vars_in[6];
		vars_out[6] = vars_in[5];
		vars_out[5] = vars_in[4];
		vars_out[4] = vars_in[3] + t1;
		vars_out[3] = vars_in[2];
		vars_out[2] = vars_in[1];
		vars_out[1] = vars_in[0];
		vars_out[0] = t1 + t2;
	end
endmodule

// ----- design/sha256_stream_hasher_core.sv -----
// SHA-256 hasher over a byte stream.
// Input channel in_ch (sink): payload kind / message_byte. kind = byte stores
// one message byte; kind = finish pads the message, compresses and emits the
// digest. Output channel out_ch (source): eight transactions of digest_word,
// word 0 first, last_word set on the eighth.
// Message bytes are taken one per cycle while a block fills. The 64th byte of
// a block starts a compression, 64 rounds in ST_RUN and then the hash update
// in ST_ADD, during which in_ch.ready is low. The block words live in a
// 16-entry memory with byte-lane writes and a registered read; rounds 0..15
// read it one word per cycle, later schedule words come from a 16-word shift
// window. A finish sweeps one word per cycle from the fill word to word 15,
// then compresses. With 56 or more bytes in the block a second sweep over all
// 16 words and a second compression follow. The digest is then offered as
// eight output transactions. The output holds while out_ch.ready is low and
// the block takes no new input until the last digest word has been accepted.
// Reset (arst_n low) restores the initial hash values and clears the bit
// count; the block memory is not cleared, since padding writes every word
// past the message before it is read.
module sha256_stream_hasher_core (
	input  logic clk,
	input  logic arst_n,
	sha_stream_if.sink   in_ch,
	sha_stream_if.source out_ch
);
	import sha_pkg::*;

	// Block word memory: byte-lane write port, registered read port
	word_t       blk_mem [16];
	word_t       rd_data_q;
	logic [3:0]  rd_addr;
	logic        wr_en;
	logic [3:0]  wr_addr;
	logic [3:0]  wr_be;
	word_t       wr_data;

	word_t       hash_q [8];
	word_t       vars_q [8];
	word_t       vars_nx [8];
	word_t       sched_q [16];
	word_t       w_q;
	logic [63:0] bit_cnt_q;
	state_t      state_q, state_d;
	logic [5:0]  rnd_q;
	logic [3:0]  pad_q;
	logic [2:0]  emit_q;
	logic        finish_q;  // compression belongs to a finish
	logic        split_q;   // padding spills into a second block
	logic        tail_q;    // second padding block: zeros and length only

	logic [5:0]  used;
	logic        in_fire;
	word_t       w_cur, w_nx, x0, x1, s0w, s1w, k_cur;

	assign used    = bit_cnt_q[8:3];
	assign in_fire = in_ch.valid && in_ch.ready;
	assign rd_addr = (state_q == ST_RUN) ? (rnd_q[3:0] + 4'd1) : 4'd0;

	// Schedule: word for this round and lookahead for the next one
	always_comb begin
		x0   = sched_q[2];
		x1   = sched_q[15];
		s0w  = {x0[6:0], x0[31:7]} ^ {x0[17:0], x0[31:18]} ^ (x0 >> 3);
		s1w  = {x1[16:0], x1[31:17]} ^ {x1[18:0], x1[31:19]} ^ (x1 >> 10);
		w_nx = sched_q[1] + s1w + sched_q[10] + s0w;
		if (rnd_q < 6'd16)
			w_cur = rd_data_q;
		else
			w_cur = w_q;
		k_cur = round_k(rnd_q);
	end

	sha_round u_round (
		.vars_in (vars_q),
		.w       (w_cur),
		.k       (k_cur),
		.vars_out(vars_nx)
	);

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = (state_q == ST_EMIT);
	assign out_ch.payload     = '{digest_word: hash_q[emit_q], last_word: (emit_q == 3'd7)};

	// Memory write port: message bytes, pad byte, zeros and length
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pad_q;
		wr_be   = 4'b1111;
		wr_data = '0;
		if (state_q == ST_IDLE && in_fire && in_ch.payload.kind == KIND_BYTE) begin
			wr_en   = 1'b1;
			wr_addr = used[5:2];
			wr_be   = 4'b1000 >> used[1:0];
			wr_data = {4{in_ch.payload.message_byte}};
		end else if (state_q == ST_PAD) begin
			wr_en = 1'b1;
			if (!tail_q && pad_q == used[5:2]) begin
				// pad byte, stale lanes behind it cleared
				wr_be   = 4'b1111 >> used[1:0];
				wr_data = {PadByte, 24'd0} >> {used[1:0], 3'd0};
			end else if (!split_q && pad_q == 4'd14) begin
				wr_data = bit_cnt_q[63:32];
			end else if (!split_q && pad_q == 4'd15) begin
				wr_data = bit_cnt_q[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < 4; b++)
			if (wr_en && wr_be[b]) blk_mem[wr_addr][8*b +: 8] <= wr_data[8*b +: 8];
		rd_data_q <= blk_mem[rd_addr];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_ch.payload.kind == KIND_FINISH)
						state_d = ST_PAD;
					else if (used == 6'd63)
						state_d = ST_RUN;
				end
			end
			ST_PAD:  if (pad_q == 4'd15) state_d = ST_RUN;
			ST_RUN:  if (rnd_q == 6'd63) state_d = ST_ADD;
			ST_ADD: begin
				if (!finish_q)
					state_d = ST_IDLE;
				else if (split_q)
					state_d = ST_PAD;
				else
					state_d = ST_EMIT;
			end
			ST_EMIT: if (out_ch.ready && emit_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Datapath and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= init_hash(3'(i));
				vars_q[i] <= '0;
			end
			for (int i = 0; i < 16; i++) sched_q[i] <= '0;
			w_q       <= '0;
			bit_cnt_q <= '0;
			rnd_q     <= '0;
			pad_q     <= '0;
			emit_q    <= '0;
			finish_q  <= 1'b0;
			split_q   <= 1'b0;
			tail_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rnd_q <= '0;
					if (in_fire) begin
						if (in_ch.payload.kind == KIND_BYTE) begin
							bit_cnt_q <= bit_cnt_q + 64'd8;
							finish_q  <= 1'b0;
							if (used == 6'd63)
								for (int i = 0; i < 8; i++) vars_q[i] <= hash_q[i];
						end else begin
							finish_q <= 1'b1;
							split_q  <= (used >= 6'd56);
							tail_q   <= 1'b0;
							pad_q    <= used[5:2];
						end
					end
				end
				ST_PAD: begin
					// Sweep one word per cycle up to word 15
					pad_q <= pad_q + 4'd1;
					rnd_q <= '0;
					if (pad_q == 4'd15)
						for (int i = 0; i < 8; i++) vars_q[i] <= hash_q[i];
				end
				ST_RUN: begin
					vars_q <= vars_nx;
					for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i + 1];
					sched_q[15] <= w_cur;
					w_q   <= w_nx;
					rnd_q <= rnd_q + 6'd1;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + vars_q[i];
					emit_q <= '0;
					if (finish_q && split_q) begin
						split_q <= 1'b0;
						tail_q  <= 1'b1;
						pad_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							for (int i = 0; i < 8; i++) hash_q[i] <= init_hash(3'(i));
							bit_cnt_q <= '0;
							finish_q  <= 1'b0;
							tail_q    <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import sha_pkg::*;

	logic clk;
	logic arst_n;
	int   n_errors;
	int   hold_cycles;
	bit   calm;

	sha_stream_if #(.payload_t(in_item_t))  in_ch ();
	sha_stream_if #(.payload_t(out_item_t)) out_ch ();

	sha256_stream_hasher_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		n_errors++;
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	// Digest model: tracks one running message and queues the words it produces
	class digest_board;
		bit [31:0] hash_st [8];
		bit [31:0] msg_blk [16];
		bit [63:0] msg_bits;
		out_item_t digest_q [$];

		function new();
			restart();
		endfunction

		function void restart();
			bit [31:0] iv [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
			hash_st = iv;
			foreach (msg_blk[i]) msg_blk[i] = '0;
			msg_bits = '0;
		endfunction

		function bit [31:0] ror(bit [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void set_byte(int pos, bit [7:0] b);
			msg_blk[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
		endfunction

		// 64 rounds; msg_blk doubles as the rolling schedule
		function void compress();
			bit [31:0] kk [64] = '{
				32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
				32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
				32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
				32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
				32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
				32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
				32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
				32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
				32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
				32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
				32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
				32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
				32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
			bit [31:0] v [8];
			bit [31:0] x0, x1, s0, s1, w, t1, t2;
			v = hash_st;
			for (int j = 0; j < 64; j++) begin
				if (j >= 16) begin
					x0 = msg_blk[(j + 1) % 16];
					x1 = msg_blk[(j + 14) % 16];
					s0 = ror(x0, 7) ^ ror(x0, 18) ^ (x0 >> 3);
					s1 = ror(x1, 17) ^ ror(x1, 19) ^ (x1 >> 10);
					msg_blk[j % 16] += s1 + msg_blk[(j + 9) % 16] + s0;
				end
				w = msg_blk[j % 16];
				t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + kk[j] + w;
				t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			foreach (hash_st[i]) hash_st[i] += v[i];
		endfunction

		function void note_input(in_item_t it);
			int fill;
			out_item_t o;
			fill = int'(msg_bits[8:3]);
			if (it.kind == KIND_BYTE) begin
				set_byte(fill, it.message_byte);
				msg_bits += 64'd8;
				if (fill == 63) compress();
				return;
			end
			// padding: marker, zeros, length; spills into a second block past 55 bytes
			set_byte(fill, PadByte);
			if (fill + 1 > 56) begin
				for (int p = fill + 1; p < 64; p++) set_byte(p, 8'h00);
				compress();
				for (int p = 0; p < 56; p++) set_byte(p, 8'h00);
			end else begin
				for (int p = fill + 1; p < 56; p++) set_byte(p, 8'h00);
			end
			msg_blk[14] = msg_bits[63:32];
			msg_blk[15] = msg_bits[31:0];
			compress();
			for (int k = 0; k < 8; k++) begin
				o.digest_word = hash_st[k];
				o.last_word   = (k == 7);
				digest_q.push_back(o);
			end
			restart();
		endfunction

		task check_result(out_item_t got);
			out_item_t want;
			if (digest_q.size() == 0) begin
				report("unexpected digest word", got.digest_word, '0);
				return;
			end
			want = digest_q.pop_front();
			if (got.digest_word !== want.digest_word)
				report("digest_word", got.digest_word, want.digest_word);
			if (got.last_word !== want.last_word)
				report("last_word", 32'(got.last_word), 32'(want.last_word));
		endtask
	endclass

	digest_board sb = new();

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Transaction monitor for both channels
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.payload);
		if (arst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
	end

	// Watchdog: cycles without any transaction
	initial begin
		int idle_cnt;
		idle_cnt = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt = 0;
			else idle_cnt++;
			if (idle_cnt >= 5000) begin
				$display("timeout");
				$display("FAIL sha256_stream_hasher_core");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random stalls, plus a long hold-off when requested
	initial begin
		int gap;
		out_ch.ready <= 1'b0;
		gap = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				gap = pick_gap();
			end
		end
	end

	// Calm stretches with no idling on either side
	initial begin
		calm = 1'b0;
		forever begin
			repeat (300) @(posedge clk);
			calm = ($urandom_range(0, 3) == 0);
		end
	end

	task automatic send_item(input logic kind, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= '{kind: kind, message_byte: b};
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) send_item(KIND_BYTE, 8'($urandom));
		send_item(KIND_FINISH, 8'($urandom));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.digest_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		n_errors    = 0;
		hold_cycles = 0;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message twice, back-to-back finishes
		send_item(KIND_FINISH, 8'h00);
		send_item(KIND_FINISH, 8'hff);
		// sender pauses until every digest word is out
		drain();

		// Long receiver hold-off while the sender keeps offering
		hold_cycles = 400;
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_BYTE, 8'hff);
		send_item(KIND_FINISH, 8'h00);

		// One full block, then 56 bytes left over so padding spills into a second block
		send_message(120);
		drain();
		repeat (200) @(posedge clk);

		if (n_errors == 0 && sb.digest_q.size() == 0) begin
			$display("PASS sha256_stream_hasher_core");
		end else begin
			$display("FAIL sha256_stream_hasher_core");
		end
		$finish;
	end

endmodule
